### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, command codes, transaction payload structs, the
// sequencer state type and the screen store request bundle.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry and the field widths of the command port.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // Character and attribute constants.
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // Command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SETPOS = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes and port geometry.
  localparam int          PADDR_W = 3;
  localparam logic        REG_FG  = 1'b0;
  localparam logic        REG_BG  = 1'b1;
  localparam logic [3:0]  FG_RESET = 4'd7;
  localparam logic [3:0]  BG_RESET = 4'd0;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_line;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } tcw_state_t;

  // One write port and one registered read port into the screen store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_mem_req_t;

endpackage

### sv/tcw_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcw_cfg_regs: colour configuration registers
// APB-style slave holding the foreground and background colour indexes and
// presenting the current attribute byte to the sequencer.
// ----------------------------------------------------------------------------
module tcw_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  attr
);
  import tcw_pkg::*;

  logic [3:0] fg;
  logic [3:0] bg;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FG:  fg <= pwdata[3:0];
        REG_BG:  bg <= pwdata[3:0];
        default: fg <= fg;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_sel)
      REG_FG:  prdata = {28'd0, fg};
      REG_BG:  prdata = {28'd0, bg};
      default: prdata = 32'd0;
    endcase
  end

  assign attr = {bg, fg};

endmodule

### sv/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram: character and attribute screen store
// One cell per screen position, low byte character and high byte attribute,
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic                  clk,
  input  tcw_pkg::tcw_mem_req_t req,
  output logic [15:0]           rdata
);
  import tcw_pkg::*;

  logic [15:0] mem [CELLS];

  // Write and registered read; the sequencer never reads and writes one cell
  // in the same cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: command sequencer of the text console writer
// Holds the cursor, decodes commands and steps a single cell counter through
// the screen store for the power-up clear, the clear command and scrolling.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tcw_pkg::tcw_in_t      cmd,
  output logic                  busy,
  output logic                  done,
  output tcw_pkg::tcw_out_t     res,
  input  logic [7:0]            attr,
  output tcw_pkg::tcw_mem_req_t mem_req,
  input  logic [15:0]           rdata
);
  import tcw_pkg::*;

  tcw_state_t       state;
  tcw_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [COL_W-1:0] cursor_x;
  logic [COL_W-1:0] cursor_x_next;
  logic [ROW_W-1:0] cursor_y;
  logic [ROW_W-1:0] cursor_y_next;
  logic             done_next;
  tcw_out_t         res_next;

  logic              accept;
  logic              is_newline;
  logic              new_row;
  logic              on_last_row;
  logic              need_scroll;
  logic              read_ok;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       blank_cell;

  // Shared decode of the command on offer.
  assign accept      = start && (state == ST_IDLE);
  assign is_newline  = (cmd.char_code == NEWLINE_CHAR);
  assign new_row     = is_newline || (cursor_x == LAST_COL);
  assign on_last_row = (cursor_y == LAST_ROW);
  assign need_scroll = (cmd.command == CMD_PUT) && new_row && on_last_row;
  assign read_ok     = (cmd.column <= LAST_COL) && (cmd.row <= LAST_ROW);
  assign cur_addr    = ADDR_W'(cursor_y) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_x);
  assign rd_addr     = ADDR_W'(cmd.row) * ADDR_W'(COLUMNS) + ADDR_W'(cmd.column);
  assign blank_cell  = {attr, BLANK_CHAR};
  assign busy        = (state != ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt == CNT_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.command)
            CMD_PUT:    state_next = need_scroll ? ST_SCROLL : ST_IDLE;
            CMD_CLEAR:  state_next = ST_CLEAR;
            CMD_READ:   state_next = read_ok ? ST_READ : ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_SCROLL: begin
        if (cnt == CNT_W'(CELLS)) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (cnt == CNT_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and output logic: cursor update, store requests and result.
  always_comb begin
    cnt_next      = cnt;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    done_next     = 1'b0;
    res_next      = res;
    mem_req       = '0;
    unique case (state)
      ST_INIT: begin
        // Power-up clear with the fixed reset attribute.
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(cnt);
        mem_req.wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_next      = (cnt == CNT_W'(CELLS - 1)) ? '0 : CNT_W'(cnt + 1'b1);
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.command)
            CMD_PUT: begin
              if (!is_newline) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_addr;
                mem_req.wdata = {attr, cmd.char_code};
              end
              if (new_row) begin
                cursor_x_next = '0;
                cursor_y_next = on_last_row ? LAST_ROW : ROW_W'(cursor_y + 1'b1);
              end else begin
                cursor_x_next = COL_W'(cursor_x + 1'b1);
              end
              if (!need_scroll) begin
                done_next = 1'b1;
                res_next  = '{cursor_x_next, cursor_y_next, 8'd0, 8'd0, 1'b0};
              end
            end
            CMD_CLEAR: begin
              cursor_x_next = '0;
              cursor_y_next = '0;
            end
            CMD_SETPOS: begin
              cursor_x_next = (cmd.column > LAST_COL) ? LAST_COL : cmd.column;
              cursor_y_next = (cmd.row > LAST_ROW) ? LAST_ROW : cmd.row;
              done_next     = 1'b1;
              res_next      = '{cursor_x_next, cursor_y_next, 8'd0, 8'd0, 1'b0};
            end
            default: begin
              if (read_ok) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rd_addr;
              end else begin
                done_next = 1'b1;
                res_next  = '{cursor_x, cursor_y, 8'd0, 8'd0, 1'b0};
              end
            end
          endcase
        end
      end
      ST_READ: begin
        done_next = 1'b1;
        res_next  = '{cursor_x, cursor_y, rdata[7:0], rdata[15:8], 1'b0};
      end
      ST_SCROLL: begin
        // Read the cell one row below and write last cycle's data one cell
        // behind; the bottom row is filled with blanks.
        if (cnt < CNT_W'(CELLS - COLUMNS)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
        end
        if (cnt != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ADDR_W'(cnt - 1'b1);
          mem_req.wdata = (cnt <= CNT_W'(CELLS - COLUMNS)) ? rdata : blank_cell;
        end
        if (cnt == CNT_W'(CELLS)) begin
          cnt_next  = '0;
          done_next = 1'b1;
          res_next  = '{cursor_x, cursor_y, 8'd0, 8'd0, 1'b1};
        end else begin
          cnt_next = CNT_W'(cnt + 1'b1);
        end
      end
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(cnt);
        mem_req.wdata = blank_cell;
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next  = '0;
          done_next = 1'b1;
          res_next  = '{cursor_x, cursor_y, 8'd0, 8'd0, 1'b0};
        end else begin
          cnt_next = CNT_W'(cnt + 1'b1);
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      cursor_x <= '0;
      cursor_y <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      done     <= done_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

### sv/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Screen store of characters and attributes with a cursor; put character,
// clear, set cursor and read cell commands, with scrolling at the bottom.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Transaction taken when
//  command   start, busy, cmd                      start high and busy low
//  result    done, res                             done high (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata  psel, penable, pwrite high
//
// A put character that does not scroll, set cursor and a read off the screen
// give their result in the cycle after the command is taken; a read on the
// screen gives it after the store's registered read and the read state.
// Clear holds busy while it writes each cell in turn and a scroll while it
// copies each row up and blanks the bottom row, as the single store write
// port moves one cell a cycle; the result comes in the cycle busy falls.
// After reset the store is cleared with busy held high;
// configuration writes are taken throughout.
// The result cannot be held off: done marks it for exactly one cycle.
//
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tcw_pkg::tcw_in_t            cmd,
  output logic                        busy,
  output logic                        done,
  output tcw_pkg::tcw_out_t           res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tcw_pkg::*;

  logic [7:0]   attr;
  tcw_mem_req_t mem_req;
  logic [15:0]  rdata;

  // Colour registers.
  tcw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  // Command sequencer and cursor.
  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .res     (res),
    .attr    (attr),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // Screen store.
  tcw_screen_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console writer
// Drives put character, clear, set cursor and read cell commands in random
// bursts through the command port, and changes the colour registers over
// the APB-style port between phases. A scoreboard keeps its own screen,
// cursor and colours, works out the status that each command should give,
// and compares every result transaction with it field by field.
// ----------------------------------------------------------------------------

import tcw_pkg::*;

// Scoreboard: screen and cursor mirror plus the queue of expected statuses.
class console_scoreboard;
  logic [15:0] screen [CELLS];
  int          cur_x;
  int          cur_y;
  logic [3:0]  fg;
  logic [3:0]  bg;
  tcw_out_t    pending_status [$];
  int          errors;
  int          results_checked;
  int          scrolls_seen;
  int          reads_on_screen;
  int          clears_done;

  function new();
    foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
    cur_x           = 0;
    cur_y           = 0;
    fg              = FG_RESET;
    bg              = BG_RESET;
    errors          = 0;
    results_checked = 0;
    scrolls_seen    = 0;
    reads_on_screen = 0;
    clears_done     = 0;
  endfunction

  function void set_colour(logic idx, logic [3:0] value);
    if (idx == REG_FG) fg = value;
    else bg = value;
  endfunction

  function logic [7:0] attr();
    return {bg, fg};
  endfunction

  function void blank_cells(int first, int last);
    for (int i = first; i < last; i++) screen[i] = {attr(), BLANK_CHAR};
  endfunction

  // Moves to the start of the next row; at the bottom the screen scrolls up.
  function bit next_line();
    cur_x = 0;
    if (cur_y + 1 >= ROWS) begin
      cur_y = ROWS - 1;
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      blank_cells(CELLS - COLUMNS, CELLS);
      return 1'b1;
    end
    cur_y++;
    return 1'b0;
  endfunction

  // Applies one accepted command and queues the status it should produce.
  function void note_command(tcw_in_t c);
    tcw_out_t r;
    r = '0;
    case (c.command)
      CMD_PUT: begin
        if (c.char_code == NEWLINE_CHAR) begin
          r.scrolled = next_line();
        end else begin
          screen[cur_y * COLUMNS + cur_x] = {attr(), c.char_code};
          cur_x++;
          if (cur_x >= COLUMNS) r.scrolled = next_line();
        end
      end
      CMD_CLEAR: begin
        blank_cells(0, CELLS);
        cur_x = 0;
        cur_y = 0;
        clears_done++;
      end
      CMD_SETPOS: begin
        cur_x = (int'(c.column) < COLUMNS) ? int'(c.column) : COLUMNS - 1;
        cur_y = (int'(c.row) < ROWS) ? int'(c.row) : ROWS - 1;
      end
      default: begin
        // A read outside the screen returns zeros.
        if (int'(c.column) < COLUMNS && int'(c.row) < ROWS) begin
          {r.cell_attr, r.cell_char} = screen[int'(c.row) * COLUMNS + int'(c.column)];
          reads_on_screen++;
        end
      end
    endcase
    r.cursor_col  = COL_W'(cur_x);
    r.cursor_line = ROW_W'(cur_y);
    if (r.scrolled) scrolls_seen++;
    pending_status.push_back(r);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Compares one result transaction with the oldest expected status.
  function void check_result(tcw_out_t got);
    tcw_out_t want;
    if (pending_status.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = pending_status.pop_front();
    results_checked++;
    report("cursor_col", want.cursor_col, got.cursor_col);
    report("cursor_line", want.cursor_line, got.cursor_line);
    report("cell_char", want.cell_char, got.cell_char);
    report("cell_attr", want.cell_attr, got.cell_attr);
    report("scrolled", want.scrolled, got.scrolled);
  endfunction
endclass

module tb;
  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  tcw_in_t            cmd     = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               done;
  tcw_out_t           res;
  logic [31:0]        prdata;
  logic               pready;

  console_scoreboard sb;
  int burst_left;
  int heavy_left;
  int items_sent;

  text_console_writer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Results are taken at the edge that ends their one-cycle strobe.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  // Sender pacing: bursts of random length, then a random gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Presents one command and holds it until the block takes it.
  task automatic issue(tcw_in_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    items_sent++;
    pace();
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_colour(logic idx, logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_colour(idx, value);
  endtask

  // Waits until every expected status has arrived and the block is free.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending_status.size() != 0 || busy) @(posedge clk);
  endtask

  function automatic tcw_in_t mk(logic [1:0] op, logic [7:0] ch, int col, int rw);
    tcw_in_t c;
    c.command   = op;
    c.char_code = ch;
    c.column    = COL_W'(col);
    c.row       = ROW_W'(rw);
    return c;
  endfunction

  // Mostly text with some newlines, cursor moves and reads; scrolls and
  // clears are costly, so they are rationed.
  function tcw_in_t random_command();
    tcw_in_t c;
    int      pick;
    bit      heavy;
    c.command   = CMD_PUT;
    c.char_code = 8'($urandom());
    c.column    = COL_W'($urandom());
    c.row       = ROW_W'($urandom());
    pick        = $urandom_range(0, 99);
    if (pick < 8) begin
      c.char_code = NEWLINE_CHAR;
    end else if (pick < 70) begin
      c.command = CMD_PUT;
    end else if (pick < 80) begin
      c.command = CMD_SETPOS;
      if ($urandom_range(0, 5) != 0) begin
        c.column = COL_W'($urandom_range(0, COLUMNS - 1));
        c.row    = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 98) begin
      c.command = CMD_READ;
      pick      = $urandom_range(0, 5);
      if (pick < 2) begin
        // The cell just written, or somewhere on the cursor row.
        c.column = COL_W'((sb.cur_x > 0) ? sb.cur_x - 1 : $urandom_range(0, COLUMNS - 1));
        c.row    = ROW_W'(sb.cur_y);
      end else if (pick < 5) begin
        c.column = COL_W'($urandom_range(0, COLUMNS - 1));
        c.row    = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else begin
      c.command = CMD_CLEAR;
    end
    heavy = (c.command == CMD_CLEAR) ||
            (c.command == CMD_PUT && sb.cur_y == ROWS - 1 &&
             (c.char_code == NEWLINE_CHAR || sb.cur_x == COLUMNS - 1));
    if (heavy) begin
      if (heavy_left == 0) begin
        c.command = CMD_SETPOS;
        c.row     = ROW_W'($urandom_range(0, ROWS - 2));
      end else begin
        heavy_left--;
      end
    end
    return c;
  endfunction

  // Main sequence: directed checks, then random phases with new colours.
  initial begin
    logic [3:0] f;
    logic [3:0] b;
    sb         = new();
    burst_left = 0;
    heavy_left = 120;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait_idle();

    // Directed part at the reset colours.
    issue(mk(CMD_READ, 8'h00, 0, 0));
    issue(mk(CMD_PUT, 8'h41, 127, 31));
    issue(mk(CMD_PUT, 8'h00, 0, 0));
    issue(mk(CMD_PUT, 8'hFF, 0, 0));
    issue(mk(CMD_READ, 8'h00, 0, 0));
    issue(mk(CMD_READ, 8'h00, 1, 0));
    issue(mk(CMD_READ, 8'hFF, 2, 0));
    issue(mk(CMD_PUT, NEWLINE_CHAR, 0, 0));
    // Positions beyond the screen saturate; reads beyond it give zeros.
    issue(mk(CMD_SETPOS, 8'h00, 127, 31));
    issue(mk(CMD_READ, 8'h00, 127, 31));
    issue(mk(CMD_READ, 8'h00, COLUMNS, 0));
    issue(mk(CMD_READ, 8'h00, 0, ROWS));
    // Wrap at the bottom right corner, then a newline on the last row.
    issue(mk(CMD_SETPOS, 8'h00, COLUMNS - 1, ROWS - 1));
    issue(mk(CMD_PUT, 8'h78, 0, 0));
    issue(mk(CMD_READ, 8'h00, COLUMNS - 1, ROWS - 2));
    issue(mk(CMD_READ, 8'h00, 0, ROWS - 1));
    issue(mk(CMD_PUT, NEWLINE_CHAR, 5, 5));
    issue(mk(CMD_READ, 8'h00, 0, 0));
    // Wrap in mid screen does not scroll.
    issue(mk(CMD_SETPOS, 8'h00, COLUMNS - 1, 10));
    issue(mk(CMD_PUT, 8'h7A, 0, 0));
    issue(mk(CMD_READ, 8'h00, COLUMNS - 1, 10));
    issue(mk(CMD_CLEAR, 8'hFF, 127, 31));
    issue(mk(CMD_READ, 8'h00, COLUMNS - 1, ROWS - 1));
    issue(mk(CMD_SETPOS, 8'hFF, 0, 0));
    wait_idle();

    // Random phases, each under its own colour setting.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          f = 4'hF;
          b = 4'hF;
        end
        1: begin
          f = 4'h0;
          b = 4'h0;
        end
        3: begin
          f = 4'h0;
          b = 4'hF;
        end
        default: begin
          f = 4'($urandom());
          b = 4'($urandom());
        end
      endcase
      write_colour(REG_FG, f);
      write_colour(REG_BG, b);
      repeat (170) issue(random_command());
      wait_idle();
    end

    repeat (16) @(posedge clk);
    sb.errors += sb.pending_status.size();
    $display("Run covered %0d commands and %0d checked results:", items_sent,
             sb.results_checked);
    $display("  %0d scrolls, %0d clears, %0d reads on the screen.", sb.scrolls_seen,
             sb.clears_done, sb.reads_on_screen);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #100_000_000;
    $display("tb: errors");
    $finish;
  end
endmodule
